// ===== rtl/core/htt_pkg.sv =====
package htt_pkg;

	localparam int NUM_BINS        = 256;
	localparam int BIN_W           = $clog2(NUM_BINS);
	localparam int MAX_PIXELS_LOG2 = 22;
	localparam int CNT_W           = MAX_PIXELS_LOG2 + 1;
	localparam int OUT_CNT_W       = 23;
	localparam int DIFF_W          = CNT_W + 1;
	localparam int PROD_W          = DIFF_W + BIN_W + 1;
	localparam int DIST_W          = PROD_W + 1;

	localparam logic [CNT_W-1:0] BIN_CAP = {1'b1, {MAX_PIXELS_LOG2{1'b0}}};

	typedef struct packed {
		logic [BIN_W-1:0] pixel;
		logic             last_pixel;
	} pix_t;

	typedef struct packed {
		logic [BIN_W-1:0]     threshold;
		logic [BIN_W-1:0]     peak_bin;
		logic [OUT_CNT_W-1:0] peak_count;
		logic [BIN_W-1:0]     min_bin;
		logic [OUT_CNT_W-1:0] min_count;
	} res_t;

	typedef struct packed {
		logic [BIN_W-1:0]         lo;
		logic [CNT_W-1:0]         hl;
		logic [BIN_W-1:0]         dx;
		logic signed [DIFF_W-1:0] dy;
	} tri_cfg_t;

endpackage

// ===== rtl/core/htt_ram.sv =====
module htt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/htt_tri.sv =====
module htt_tri (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  htt_pkg::tri_cfg_t              cfg,
	input  logic                           bin_valid,
	input  logic [htt_pkg::BIN_W-1:0]      bin_idx,
	input  logic [htt_pkg::CNT_W-1:0]      bin_count,
	output logic [htt_pkg::BIN_W-1:0]      pick,
	output logic                           busy
);

	htt_pkg::tri_cfg_t                     cfg_q;
	logic signed [htt_pkg::PROD_W-1:0]     acc_q;
	logic signed [htt_pkg::DIFF_W-1:0]     hdiff;
	logic signed [htt_pkg::BIN_W:0]        dxs;
	logic signed [htt_pkg::PROD_W-1:0]     prod;
	logic                                  v_s1;
	logic signed [htt_pkg::PROD_W-1:0]     ta_s1;
	logic signed [htt_pkg::PROD_W-1:0]     prod_s1;
	logic [htt_pkg::BIN_W-1:0]             idx_s1;
	logic signed [htt_pkg::DIST_W-1:0]     diff;
	logic [htt_pkg::DIST_W-1:0]            dist_abs;
	logic                                  v_s2;
	logic [htt_pkg::DIST_W-1:0]            d_s2;
	logic [htt_pkg::BIN_W-1:0]             idx_s2;
	logic [htt_pkg::DIST_W-1:0]            best_q;
	logic [htt_pkg::BIN_W-1:0]             pick_q;

	assign hdiff = $signed({1'b0, bin_count}) - $signed({1'b0, cfg_q.hl});
	assign dxs   = $signed({1'b0, cfg_q.dx});
	assign prod  = htt_pkg::PROD_W'(hdiff) * htt_pkg::PROD_W'(dxs);

	assign diff = $signed({ta_s1[htt_pkg::PROD_W-1], ta_s1})
		- $signed({prod_s1[htt_pkg::PROD_W-1], prod_s1});
	assign dist_abs = diff[htt_pkg::DIST_W-1] ? htt_pkg::DIST_W'(-diff)
		: htt_pkg::DIST_W'(diff);

	always_ff @(posedge clk) begin
		if (start) begin
			cfg_q <= cfg;
		end
		if (bin_valid) begin
			ta_s1   <= acc_q;
			prod_s1 <= prod;
			idx_s1  <= bin_idx;
		end
		if (v_s1) begin
			d_s2   <= dist_abs;
			idx_s2 <= idx_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			best_q <= '0;
			pick_q <= '0;
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
		end else begin
			v_s1 <= bin_valid && !start;
			v_s2 <= v_s1 && !start;
			if (start) begin
				acc_q  <= '0;
				best_q <= '0;
				pick_q <= cfg.lo;
			end else begin
				if (bin_valid) begin
					acc_q <= acc_q + htt_pkg::PROD_W'(cfg_q.dy);
				end
				if (v_s2 && d_s2 > best_q) begin
					best_q <= d_s2;
					pick_q <= idx_s2;
				end
			end
		end
	end

	assign pick = pick_q;
	assign busy = v_s1 || v_s2;

`ifndef SYNTH
	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> (acc_q == '0 && best_q == '0 && !v_s1))
		else $error("triangle unit not cleared on start");
	a_best_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(!start && v_s2) |=> best_q >= $past(best_q))
		else $error("best distance decreased");
	a_acc_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(!start && bin_valid)
		|=> acc_q == $past(acc_q) + htt_pkg::PROD_W'($past(cfg_q.dy)))
		else $error("run term did not advance by dy");
`endif

endmodule

// ===== rtl/core/histogram_triangle_threshold.sv =====
// Gray pixels (8 bits) stream in at one per cycle while pix_ready is high and each adds
// one to its bin of a 256-bin histogram held in a single-port-read RAM, with a one-deep
// forward so equal pixels may come back to back; a bin stops counting at 2^22. The pixel
// marked last starts the threshold search and pix_ready stays low until the result
// register is free and the result is loaded: every bin is walked through the RAM read
// port for the peak and minimum, then one bin per cycle from the lower to the upper end
// bin goes through the multiply and compare unit (skipped when the end bins or their
// counts are equal), and then the pipeline drains. The result waits in an output
// register; the histogram is cleared through per-bin valid bits the moment the result
// is loaded, so the next image may start at once.
module histogram_triangle_threshold (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          pix_valid,
	output logic          pix_ready,
	input  htt_pkg::pix_t pix,
	output logic          res_valid,
	input  logic          res_ready,
	output htt_pkg::res_t res
);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_WAIT  = 6'b000010,
		ST_SCAN1 = 6'b000100,
		ST_SETUP = 6'b001000,
		ST_SCAN2 = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	state_t                          st_q;
	logic                            accept;
	logic [htt_pkg::NUM_BINS-1:0]    vld_q;
	logic [htt_pkg::BIN_W-1:0]       ram_raddr;
	logic [htt_pkg::CNT_W-1:0]       ram_rdata;
	logic                            rvld_q;
	logic [htt_pkg::CNT_W-1:0]       rd_val;
	logic                            v_s1;
	logic [htt_pkg::BIN_W-1:0]       px_s1;
	logic                            wv_q;
	logic [htt_pkg::BIN_W-1:0]       wa_q;
	logic [htt_pkg::CNT_W-1:0]       wd_q;
	logic [htt_pkg::CNT_W-1:0]       bin_old;
	logic [htt_pkg::CNT_W-1:0]       bin_new;
	logic [htt_pkg::BIN_W:0]         cnt_q;
	logic                            scan_iss;
	logic                            sv_s1;
	logic [htt_pkg::BIN_W-1:0]       sidx_s1;
	logic [htt_pkg::CNT_W-1:0]       pmax_q;
	logic [htt_pkg::CNT_W-1:0]       mmin_q;
	logic [htt_pkg::BIN_W-1:0]       peak_q;
	logic [htt_pkg::BIN_W-1:0]       mn_q;
	logic [htt_pkg::BIN_W-1:0]       hi_q;
	logic                            peak_lt;
	logic [htt_pkg::BIN_W-1:0]       lo_c;
	logic [htt_pkg::BIN_W-1:0]       hi_c;
	logic [htt_pkg::CNT_W-1:0]       hr_c;
	htt_pkg::tri_cfg_t               cfg_c;
	logic                            degen;
	logic                            tri_busy;
	logic [htt_pkg::BIN_W-1:0]       tri_pick;
	logic                            done_fire;
	logic                            res_valid_q;
	htt_pkg::res_t                   res_q;

	assign pix_ready = (st_q == ST_IDLE);
	assign accept    = pix_valid && pix_ready;
	assign done_fire = (st_q == ST_DONE) && (!res_valid_q || res_ready);

	// bin update with forward of the last write held in wa_q/wd_q
	assign ram_raddr = (st_q == ST_IDLE) ? pix.pixel : cnt_q[htt_pkg::BIN_W-1:0];
	assign rd_val    = rvld_q ? ram_rdata : '0;
	assign bin_old   = (wv_q && wa_q == px_s1) ? wd_q : rd_val;
	assign bin_new   = (bin_old >= htt_pkg::BIN_CAP) ? bin_old : bin_old + 1'b1;

	htt_ram #(
		.WIDTH(htt_pkg::CNT_W),
		.DEPTH(htt_pkg::NUM_BINS)
	) u_hist (
		.clk  (clk),
		.we   (v_s1),
		.waddr(px_s1),
		.wdata(bin_new),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign scan_iss = ((st_q == ST_SCAN1) && !cnt_q[htt_pkg::BIN_W])
		|| ((st_q == ST_SCAN2) && cnt_q <= {1'b0, hi_q});

	// end points of the triangle
	assign peak_lt = peak_q < mn_q;
	assign lo_c    = peak_lt ? peak_q : mn_q;
	assign hi_c    = peak_lt ? mn_q : peak_q;
	assign hr_c    = peak_lt ? mmin_q : pmax_q;
	assign degen   = (peak_q == mn_q) || (pmax_q == mmin_q);

	always_comb begin
		cfg_c.lo = lo_c;
		cfg_c.hl = peak_lt ? pmax_q : mmin_q;
		cfg_c.dx = hi_c - lo_c;
		cfg_c.dy = $signed({1'b0, hr_c}) - $signed({1'b0, cfg_c.hl});
	end

	htt_tri u_tri (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (st_q == ST_SETUP),
		.cfg      (cfg_c),
		.bin_valid(sv_s1 && st_q == ST_SCAN2),
		.bin_idx  (sidx_s1),
		.bin_count(rd_val),
		.pick     (tri_pick),
		.busy     (tri_busy)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1 <= pix.pixel;
		end
		if (v_s1) begin
			wa_q <= px_s1;
			wd_q <= bin_new;
		end
		sidx_s1 <= cnt_q[htt_pkg::BIN_W-1:0];
		if (sv_s1 && st_q == ST_SCAN1) begin
			if (sidx_s1 == '0) begin
				pmax_q <= rd_val;
				peak_q <= '0;
				mmin_q <= rd_val;
				mn_q   <= '0;
			end else begin
				if (rd_val > pmax_q) begin
					pmax_q <= rd_val;
					peak_q <= sidx_s1;
				end
				if (rd_val <= mmin_q) begin
					mmin_q <= rd_val;
					mn_q   <= sidx_s1;
				end
			end
		end
		if (st_q == ST_SETUP) begin
			hi_q <= hi_c;
		end
		if (done_fire) begin
			res_q.threshold  <= tri_pick;
			res_q.peak_bin   <= peak_q;
			res_q.peak_count <= htt_pkg::OUT_CNT_W'(pmax_q);
			res_q.min_bin    <= mn_q;
			res_q.min_count  <= htt_pkg::OUT_CNT_W'(mmin_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			vld_q       <= '0;
			rvld_q      <= 1'b0;
			v_s1        <= 1'b0;
			wv_q        <= 1'b0;
			sv_s1       <= 1'b0;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			rvld_q <= vld_q[ram_raddr];
			v_s1   <= accept;
			wv_q   <= v_s1;
			sv_s1  <= scan_iss;
			if (v_s1) begin
				vld_q[px_s1] <= 1'b1;
			end
			if (scan_iss) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (res_valid_q && res_ready && !done_fire) begin
				res_valid_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (accept && pix.last_pixel) begin
						st_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					cnt_q <= '0;
					st_q  <= ST_SCAN1;
				end
				ST_SCAN1: begin
					if (cnt_q[htt_pkg::BIN_W] && !sv_s1) begin
						st_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					cnt_q <= {1'b0, lo_c};
					st_q  <= degen ? ST_DONE : ST_SCAN2;
				end
				ST_SCAN2: begin
					if (!scan_iss && !sv_s1 && !tri_busy) begin
						st_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (done_fire) begin
						vld_q       <= '0;
						res_valid_q <= 1'b1;
						st_q        <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

`ifndef SYNTH
	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> (st_q == ST_IDLE || st_q == ST_WAIT))
		else $error("histogram written during scan");
	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(st_q == ST_DONE))
		else $error("result raised outside done");
	a_peak_ge_min: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_SETUP) |-> pmax_q >= mmin_q)
		else $error("peak count below minimum count");
	a_pick_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_DONE && $past(st_q == ST_SCAN2)) |-> tri_pick <= hi_q)
		else $error("threshold beyond upper end bin");
	a_clear_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		done_fire |=> vld_q == '0)
		else $error("histogram not cleared after result");
`endif

endmodule
